>>> hdl/cte_pkg.sv
`timescale 1ns / 1ps

package cte_pkg;

  // Table geometry
  localparam int TABLE_ENTRIES = 64;
  localparam int SLOT_W        = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  // Field widths
  localparam int OP_W     = 3;
  localparam int HANDLE_W = 64;
  localparam int WORD_W   = 32;
  localparam int SIDX_W   = 8;

  // Stream packing
  localparam int IN_FIELDS_W  = OP_W + HANDLE_W + 2 * WORD_W + SIDX_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 1 + HANDLE_W + 3 * WORD_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Generation held by an entry that was never written
  localparam logic [WORD_W-1:0] GEN_RESET = WORD_W'(1);

  typedef logic [SLOT_W-1:0] slot_t;

  typedef enum logic [OP_W-1:0] {
    OP_CREATE   = 3'd0,
    OP_DELEGATE = 3'd1,
    OP_CHECK    = 3'd2,
    OP_AUDIT    = 3'd3,
    OP_DESTROY  = 3'd4,
    OP_SNAPSHOT = 3'd5
  } op_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  // One stored entry
  typedef struct packed {
    logic [WORD_W-1:0] item_type;
    logic [WORD_W-1:0] rights;
    logic [WORD_W-1:0] generation;
  } entry_t;

  // Flag update from the execute stage to the allocator
  typedef struct packed {
    logic  claim;
    slot_t claim_slot;
    logic  release_en;
    slot_t release_slot;
  } flag_upd_t;

endpackage

>>> hdl/capability_table_engine.sv
`timescale 1ns / 1ps

// Capability table with generational handles. A request is accepted in
// S_IDLE, where the entry table is read synchronously (the handle's entry
// and the lowest free slot are read together on two read ports); S_EXEC
// then decides, writes the entry back and loads the result register, and
// waits while an earlier result is still held by out_tready low. Used
// flags and "ever written" flags live in flip-flops cleared by reset, so
// the block is ready straight after reset with no clearing pass.
module capability_table_engine (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // opcode[2:0], handle[66:3], item_type[98:67], rights_mask[130:99],
  // snap_slot[138:131], zero fill above
  input  logic [cte_pkg::IN_TDATA_W-1:0]      in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // ok[0], out_handle[64:1], out_type[96:65], out_rights[128:97],
  // out_generation[160:129], zero fill above
  output logic [cte_pkg::OUT_TDATA_W-1:0]     out_tdata
);
  import cte_pkg::*;

  // Unpack the input transfer
  logic [OP_W-1:0]     in_op;
  logic [HANDLE_W-1:0] in_handle;
  logic [WORD_W-1:0]   in_type;
  logic [WORD_W-1:0]   in_rights;
  logic [SIDX_W-1:0]   in_sidx;

  assign in_op     = in_tdata[OP_W-1:0];
  assign in_handle = in_tdata[OP_W +: HANDLE_W];
  assign in_type   = in_tdata[OP_W + HANDLE_W +: WORD_W];
  assign in_rights = in_tdata[OP_W + HANDLE_W + WORD_W +: WORD_W];
  assign in_sidx   = in_tdata[OP_W + HANDLE_W + 2 * WORD_W +: SIDX_W];

  state_t state_r, state_nxt;
  logic   accept, exec_fire;

  // Request registers
  logic [OP_W-1:0]   op_r;
  logic [WORD_W-1:0] hgen_r;
  logic [WORD_W-1:0] type_r;
  logic [WORD_W-1:0] rights_r;
  slot_t             slot_a_r;
  logic              rng_a_r;
  logic              wrtn_a_r;
  logic              wrtn_b_r;

  // Output register
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r;

  // Allocator and memory
  flag_upd_t                upd;
  logic [TABLE_ENTRIES-1:0] used;
  logic [TABLE_ENTRIES-1:0] written;
  logic                     free_found;
  slot_t                    free_slot;
  entry_t                   ent_a, ent_b;
  logic                     wr_en;
  slot_t                    wr_addr;
  entry_t                   wr_data;

  // Read address selection at accept
  logic [WORD_W-1:0] hlow;
  logic [WORD_W-1:0] hlow_m1;
  logic              rng_h, rng_s;
  slot_t             rd_a_addr;

  assign hlow    = in_handle[WORD_W-1:0];
  assign hlow_m1 = hlow - WORD_W'(1);
  assign rng_h   = (hlow != '0) && (hlow <= WORD_W'(TABLE_ENTRIES));
  assign rng_s   = (WORD_W'(in_sidx) < WORD_W'(TABLE_ENTRIES));

  always_comb begin
    if (in_op == OP_SNAPSHOT) begin
      rd_a_addr = in_sidx[SLOT_W-1:0];
    end else begin
      rd_a_addr = hlow_m1[SLOT_W-1:0];
    end
  end

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign exec_fire = (state_r == S_EXEC) && (!out_valid_r || out_tready);

  cte_alloc u_alloc (
    .clk        (clk),
    .rst_n      (rst_n),
    .upd        (upd),
    .used       (used),
    .written    (written),
    .free_found (free_found),
    .free_slot  (free_slot)
  );

  cte_mem u_mem (
    .clk       (clk),
    .rd_en     (accept),
    .rd_a_addr (rd_a_addr),
    .rd_a_data (ent_a),
    .rd_b_addr (free_slot),
    .rd_b_data (ent_b),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  // Capture the request
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= in_op;
      hgen_r   <= in_handle[HANDLE_W-1:WORD_W];
      type_r   <= in_type;
      rights_r <= in_rights;
      slot_a_r <= rd_a_addr;
      rng_a_r  <= (in_op == OP_SNAPSHOT) ? rng_s : rng_h;
      wrtn_a_r <= written[rd_a_addr];
      wrtn_b_r <= written[free_slot];
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec_fire) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Execute: decide, write back, form the result
  logic [WORD_W-1:0]   gen_a, gen_b, gen_inc;
  logic                used_a, live, subset;
  logic                ok;
  logic [HANDLE_W-1:0] res_handle;
  logic [WORD_W-1:0]   res_type, res_rights, res_gen;
  logic                do_claim, do_release;
  entry_t              claim_data, release_data;
  op_t                 op;

  assign op      = op_t'(op_r);
  assign gen_a   = wrtn_a_r ? ent_a.generation : GEN_RESET;
  assign gen_b   = wrtn_b_r ? ent_b.generation : GEN_RESET;
  assign gen_inc = gen_a + WORD_W'(1);
  assign used_a  = used[slot_a_r];
  assign live    = rng_a_r && used_a && (gen_a == hgen_r);
  assign subset  = ((ent_a.rights & rights_r) == rights_r);

  always_comb begin
    ok           = 1'b0;
    res_handle   = '0;
    res_type     = '0;
    res_rights   = '0;
    res_gen      = '0;
    do_claim     = 1'b0;
    do_release   = 1'b0;
    claim_data   = '{item_type: type_r, rights: rights_r, generation: gen_b};
    release_data = '{item_type: '0, rights: '0,
                     generation: (gen_inc == '0) ? GEN_RESET : gen_inc};
    case (op)
      OP_CREATE: begin
        if (free_found) begin
          ok         = 1'b1;
          do_claim   = 1'b1;
          res_handle = {gen_b, WORD_W'(free_slot) + WORD_W'(1)};
        end
      end
      OP_DELEGATE: begin
        claim_data.item_type = ent_a.item_type;
        if (live && subset && free_found) begin
          ok         = 1'b1;
          do_claim   = 1'b1;
          res_handle = {gen_b, WORD_W'(free_slot) + WORD_W'(1)};
        end
      end
      OP_CHECK: begin
        ok = live && subset && (ent_a.item_type == type_r);
      end
      OP_AUDIT: begin
        if (live) begin
          ok         = 1'b1;
          res_type   = ent_a.item_type;
          res_rights = ent_a.rights;
          res_gen    = gen_a;
        end
      end
      OP_DESTROY: begin
        if (live) begin
          ok         = 1'b1;
          do_release = 1'b1;
        end
      end
      OP_SNAPSHOT: begin
        if (rng_a_r && used_a) begin
          ok         = 1'b1;
          res_handle = {gen_a, WORD_W'(slot_a_r) + WORD_W'(1)};
          res_type   = ent_a.item_type;
          res_rights = ent_a.rights;
          res_gen    = gen_a;
        end
      end
      default: ok = 1'b0;
    endcase
  end

  // Drive write-back and flag updates on the execute edge only
  always_comb begin
    upd.claim        = exec_fire && do_claim;
    upd.claim_slot   = free_slot;
    upd.release_en   = exec_fire && do_release;
    upd.release_slot = slot_a_r;
    wr_en            = exec_fire && (do_claim || do_release);
    wr_addr          = do_claim ? free_slot : slot_a_r;
    wr_data          = do_claim ? claim_data : release_data;
  end

  // Result register: load on execute, drop on output transfer
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (exec_fire) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      out_data_r <= OUT_TDATA_W'({res_gen, res_rights, res_type, res_handle, ok});
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

>>> hdl/cte_mem.sv
`timescale 1ns / 1ps

module cte_mem (
  input  logic            clk,
  input  logic            rd_en,
  input  cte_pkg::slot_t  rd_a_addr,
  output cte_pkg::entry_t rd_a_data,
  input  cte_pkg::slot_t  rd_b_addr,
  output cte_pkg::entry_t rd_b_data,
  input  logic            wr_en,
  input  cte_pkg::slot_t  wr_addr,
  input  cte_pkg::entry_t wr_data
);
  import cte_pkg::*;

  entry_t mem [TABLE_ENTRIES];

  // Write one entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read two entries, hold data between reads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_a_data <= mem[rd_a_addr];
      rd_b_data <= mem[rd_b_addr];
    end
  end

endmodule

>>> hdl/cte_alloc.sv
`timescale 1ns / 1ps

module cte_alloc (
  input  logic                             clk,
  input  logic                             rst_n,
  input  cte_pkg::flag_upd_t               upd,
  output logic [cte_pkg::TABLE_ENTRIES-1:0] used,
  output logic [cte_pkg::TABLE_ENTRIES-1:0] written,
  output logic                             free_found,
  output cte_pkg::slot_t                   free_slot
);
  import cte_pkg::*;

  logic [TABLE_ENTRIES-1:0] used_r, used_nxt;
  logic [TABLE_ENTRIES-1:0] wrtn_r, wrtn_nxt;

  // Apply claim and release to the flags
  always_comb begin
    used_nxt = used_r;
    wrtn_nxt = wrtn_r;
    if (upd.claim) begin
      used_nxt[upd.claim_slot] = 1'b1;
      wrtn_nxt[upd.claim_slot] = 1'b1;
    end
    if (upd.release_en) begin
      used_nxt[upd.release_slot] = 1'b0;
      wrtn_nxt[upd.release_slot] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
      wrtn_r <= '0;
    end else begin
      used_r <= used_nxt;
      wrtn_r <= wrtn_nxt;
    end
  end

  // Find the lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_found = 1'b1;
        free_slot  = SLOT_W'(i);
      end
    end
  end

  assign used    = used_r;
  assign written = wrtn_r;

endmodule
